// ===== hdl/lpfs_pkg.sv =====
package lpfs_pkg;

  // Hunting window and frame layout
  localparam int WIN_LEN   = 13;
  localparam int LEN_BYTES = 4;
  localparam int MARK_POS  = 5;
  localparam int MARK_LEN  = 8;
  localparam int DATA_POS  = 4;
  localparam int MIN_LEN   = 9;
  localparam int BURST_LEN = 9;
  localparam int LEN_W     = 8 * LEN_BYTES;
  localparam int FILL_W    = $clog2(WIN_LEN + 1);
  localparam int IDX_W     = $clog2(BURST_LEN);

  // ASCII "MsgCount", first marker byte in the lowest bits
  localparam logic [8*MARK_LEN-1:0] SYNC_MARK = 64'h746E_756F_4367_734D;

  // Configuration
  localparam int              MAX_LEN_W        = 14;
  localparam logic [13:0]     MAX_LEN_RST      = 14'd16380;
  localparam int              BUFFER_BYTES_DEF = 16384;
  localparam int              QUEUE_DEPTH_DEF  = 4;

  // Commands from the front to the back
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_BYTE  = 2'd0;  // one pass-through payload byte
  localparam cmd_kind_t CMD_BURST = 2'd1;  // nine window bytes opening a frame
  localparam cmd_kind_t CMD_ERR   = 2'd2;  // length out of range

  typedef struct packed {
    cmd_kind_t                  kind;
    logic                       last;
    logic [8*BURST_LEN-1:0]     data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

// ===== hdl/lpfs_queue.sv =====
module lpfs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfs_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output lpfs_pkg::cmd_t      pop_cmd,
  output lpfs_pkg::q_status_t status
);
  import lpfs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.full      = (count_r == CW'(DEPTH));
  assign status.not_empty = (count_r != '0);
  assign pop_cmd          = mem_r[rptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.not_empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/lpfs_front.sv =====
module lpfs_front #(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,
  input  logic [lpfs_pkg::MAX_LEN_W-1:0]     max_len,
  input  logic                               q_full,
  output logic                               push,
  output lpfs_pkg::cmd_t                     push_cmd
);
  import lpfs_pkg::*;

  localparam int LIMIT_CAP_I = (BUFFER_BYTES - 4 > (1 << MAX_LEN_W) - 1) ?
                               (1 << MAX_LEN_W) - 1 : BUFFER_BYTES - 4;
  localparam logic [MAX_LEN_W-1:0] LIMIT_CAP = MAX_LEN_W'(LIMIT_CAP_I);

  logic [7:0]              win_r [WIN_LEN];
  logic [7:0]              win_nxt [WIN_LEN];
  logic [7:0]              win_sh [WIN_LEN];
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic                    in_payload_r, in_payload_nxt;
  logic [MAX_LEN_W-1:0]    rem_r, rem_nxt;

  logic                    accept;
  logic [8*MARK_LEN-1:0]   mark;
  logic [LEN_W-1:0]        len;
  logic [8*BURST_LEN-1:0]  head;
  logic [MAX_LEN_W-1:0]    limit;
  logic                    len_bad;
  logic                    is_match;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  // Window as it stands once this byte is shifted in
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_sh[i] = win_r[i+1];
    end
    win_sh[WIN_LEN-1] = in_tdata;
    for (int i = 0; i < MARK_LEN; i++) begin
      mark[8*i +: 8] = win_sh[MARK_POS+i];
    end
    for (int i = 0; i < LEN_BYTES; i++) begin
      len[8*i +: 8] = win_sh[i];
    end
    for (int i = 0; i < BURST_LEN; i++) begin
      head[8*i +: 8] = win_sh[DATA_POS+i];
    end
  end

  assign limit    = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
  assign is_match = (mark == SYNC_MARK);
  assign len_bad  = (len < LEN_W'(MIN_LEN)) || (len > LEN_W'(limit));

  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    rem_nxt        = rem_r;
    push           = 1'b0;
    push_cmd       = '0;
    if (accept) begin
      if (in_payload_r) begin
        push              = 1'b1;
        push_cmd.kind     = CMD_BYTE;
        push_cmd.data[7:0] = in_tdata;
        push_cmd.last     = (rem_r <= MAX_LEN_W'(1));
        if (rem_r <= MAX_LEN_W'(1)) begin
          in_payload_nxt = 1'b0;
          rem_nxt        = '0;
          fill_nxt       = '0;
        end else begin
          rem_nxt = rem_r - 1'b1;
        end
      end else begin
        win_nxt = win_sh;
        if (fill_r != FILL_W'(WIN_LEN - 1)) begin
          fill_nxt = fill_r + 1'b1;
        end else if (is_match && len_bad) begin
          // drop oldest, keep hunting
          push          = 1'b1;
          push_cmd.kind = CMD_ERR;
        end else if (is_match) begin
          push          = 1'b1;
          push_cmd.kind = CMD_BURST;
          push_cmd.data = head;
          push_cmd.last = (len == LEN_W'(MIN_LEN));
          fill_nxt      = '0;
          if (len != LEN_W'(MIN_LEN)) begin
            in_payload_nxt = 1'b1;
            rem_nxt        = len[MAX_LEN_W-1:0] - MAX_LEN_W'(MIN_LEN);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      rem_r        <= '0;
    end else begin
      fill_r       <= fill_nxt;
      in_payload_r <= in_payload_nxt;
      rem_r        <= rem_nxt;
    end
  end

endmodule

// ===== hdl/lpfs_back.sv =====
module lpfs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  lpfs_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [1:0]     out_tuser
);
  import lpfs_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BURST_LEN - 1);

  cmd_t             cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             advance;
  logic             done;

  assign advance = cur_valid_r && out_tready;
  assign done    = (cur_r.kind != CMD_BURST) || (idx_r == IDX_LAST);
  assign q_pop   = q_not_empty && (!cur_valid_r || (advance && done));

  assign out_tvalid = cur_valid_r;
  assign out_tdata  = cur_r.data[8*idx_r +: 8];

  always_comb begin
    out_tlast = 1'b0;
    out_tuser = 2'b00;
    case (cur_r.kind)
      CMD_BYTE: begin
        out_tlast = cur_r.last;
      end
      CMD_BURST: begin
        out_tlast    = cur_r.last && (idx_r == IDX_LAST);
        out_tuser[0] = (idx_r == '0);
      end
      CMD_ERR: begin
        out_tuser[1] = 1'b1;
      end
      default: begin
        out_tlast = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_nxt       = q_cmd;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (advance) begin
      if (done) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== hdl/length_prefixed_frame_sync.sv =====
// Channel   Direction  Beat contents
// in_       slave      tdata[7:0] rx_byte
// out_      master     tdata[7:0] payload_byte, tlast frame_last,
//                      tuser[0] frame_first, tuser[1] length_error
// cfg_      slave      data[13:0] max_payload_length
//
// One byte is taken per cycle while the command queue has room. A payload
// byte passes through a queue entry, then the back output register. A
// marker hit queues nine output beats; the back drains one beat a cycle
// while out_tready stays high, so the command queue can fill and in_tready
// drops after a hit. A held out_tready backs up through the queue to
// in_tready. Synchronous active-low reset clears the window fill, frame
// state, queue and output valid, and loads max_payload_length with 16380.
module length_prefixed_frame_sync #(
  parameter int BUFFER_BYTES = lpfs_pkg::BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH  = lpfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,    // [7:0] rx_byte
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,   // [7:0] payload_byte
  output logic                            out_tlast,   // frame_last
  output logic [1:0]                      out_tuser,   // [0] frame_first, [1] length_error
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpfs_pkg::MAX_LEN_W-1:0]  cfg_data     // [13:0] max_payload_length
);
  import lpfs_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_r, max_len_nxt;
  logic                 push;
  cmd_t                 push_cmd;
  logic                 pop;
  cmd_t                 pop_cmd;
  q_status_t            q_status;

  // Config is always taken; the user must write only while the block is idle, unchecked
  assign cfg_ready   = 1'b1;
  assign max_len_nxt = cfg_valid ? cfg_data : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // Front: hunt for the marker, turn marker hits and payload bytes into commands
  lpfs_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .max_len   (max_len_r),
    .q_full    (q_status.full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short command queue decouples the hunting side from the output side
  lpfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  // Back: expand commands into output beats
  lpfs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_status.not_empty),
    .q_cmd       (pop_cmd),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== dv/tb_length_prefixed_frame_sync.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_frame_sync;
  import lpfs_pkg::*;

  // Allow a long receiver stall plus a long sender gap plus the settle pause
  localparam int unsigned IDLE_LIMIT    = 2000;
  // Cycles to wait after the last due beat: front and back registers plus a
  // nine-beat burst drain, with margin
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LEN_CAP       = BUFFER_BYTES_DEF - LEN_BYTES;

  // One output beat as the checker sees it
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       err;
  } frame_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic [1:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [MAX_LEN_W-1:0] cfg_data = '0;

  length_prefixed_frame_sync DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Byte stream waiting to be sent, and beats the deframer still owes us
  logic [7:0]  rx_bytes_q [$];
  frame_beat_t beats_due [$];

  // Shadow copy of the deframer state
  logic [7:0]           hunt_win [WIN_LEN];
  int unsigned          win_fill = 0;
  logic                 frame_open = 1'b0;
  logic [13:0]          payload_left = '0;
  logic [MAX_LEN_W-1:0] max_len_reg = MAX_LEN_RST;

  // Limit in force as the stimulus sees it, used to shape frame lengths
  int unsigned limit_now = MAX_LEN_RST;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        in_taken = 1'b0;

  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;

  initial begin
    for (int k = 0; k < WIN_LEN; k++) hunt_win[k] = '0;
  end

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short hole, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_beat(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Shift the hunting window down by one and leave twelve bytes held
  task automatic drop_oldest_byte();
    for (int k = 0; k < WIN_LEN - 1; k++) hunt_win[k] = hunt_win[k + 1];
    hunt_win[WIN_LEN - 1] = '0;
    win_fill = WIN_LEN - 1;
  endtask

  // Advance the shadow deframer by one received byte and queue the beats it owes
  task automatic predict_rx_byte(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    int unsigned      lim;
    logic             hit;
    logic             done;
    // Inside a frame every byte passes straight through
    if (frame_open) begin
      done = (payload_left <= 14'd1);
      beats_due.push_back('{data: b, first: 1'b0, last: done, err: 1'b0});
      if (done) begin
        frame_open   = 1'b0;
        payload_left = '0;
        win_fill     = 0;
      end else begin
        payload_left = payload_left - 14'd1;
      end
      return;
    end
    if (win_fill >= WIN_LEN) drop_oldest_byte();
    hunt_win[win_fill] = b;
    win_fill++;
    // Window still filling: store only
    if (win_fill < WIN_LEN) return;
    hit = 1'b1;
    for (int k = 0; k < MARK_LEN; k++)
      if (hunt_win[MARK_POS + k] != SYNC_MARK[8*k +: 8]) hit = 1'b0;
    if (!hit) begin
      drop_oldest_byte();
      return;
    end
    len = {hunt_win[3], hunt_win[2], hunt_win[1], hunt_win[0]};
    lim = (max_len_reg > LEN_CAP) ? LEN_CAP : max_len_reg;
    // Length out of range: one error beat, then keep hunting
    if (len < MIN_LEN || len > lim) begin
      beats_due.push_back('{data: 8'h00, first: 1'b0, last: 1'b0, err: 1'b1});
      drop_oldest_byte();
      return;
    end
    // Marker hit: window bytes 4..12 open the frame
    for (int k = 0; k < BURST_LEN; k++)
      beats_due.push_back('{data: hunt_win[DATA_POS + k], first: (k == 0),
                            last: (k == BURST_LEN - 1 && len == MIN_LEN), err: 1'b0});
    win_fill = 0;
    if (len == MIN_LEN) begin
      frame_open   = 1'b0;
      payload_left = '0;
    end else begin
      frame_open   = 1'b1;
      payload_left = 14'(len - MIN_LEN);
    end
  endtask

  // Sender: change in_ on the falling edge, hold a beat until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the current beat
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (rx_bytes_q.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= rx_bytes_q.pop_front();
      // Pick the hole that follows this beat; now and then run with no holes
      if (send_calm != 0) begin
        send_calm--;
        send_gap = 0;
      end else begin
        send_gap = idle_len();
        if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(16, 64);
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure on out_, with calm stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (recv_calm != 0) begin
        recv_calm--;
      end else begin
        stall_left = idle_len();
        if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(16, 64);
      end
    end
  end

  // Monitor: sample every channel on the rising edge
  always @(posedge clk) begin : monitor
    frame_beat_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      // Predict before checking so a same-edge result still finds its entry
      if (in_tvalid && in_tready) predict_rx_byte(in_tdata);
      if (cfg_valid && cfg_ready) max_len_reg = cfg_data;
      if (out_tvalid && out_tready) begin
        if (beats_due.size() == 0) begin
          flag_beat("unexpected beat, payload_byte", out_tdata, 0);
        end else begin
          want = beats_due.pop_front();
          if (out_tdata !== want.data)
            flag_beat("payload_byte", out_tdata, want.data);
          if (out_tuser[0] !== want.first)
            flag_beat("frame_first", out_tuser[0], want.first);
          if (out_tlast !== want.last)
            flag_beat("frame_last", out_tlast, want.last);
          if (out_tuser[1] !== want.err)
            flag_beat("length_error", out_tuser[1], want.err);
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL length_prefixed_frame_sync");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Queue one frame: little-endian length, one data byte, the marker, then the
  // rest of the payload if the block should accept it. Broken frames get one
  // marker byte corrupted and no payload.
  task automatic push_frame(input logic [31:0] len, input bit broken);
    int unsigned bad;
    bad = broken ? $urandom_range(0, MARK_LEN - 1) : MARK_LEN;
    for (int k = 0; k < LEN_BYTES; k++) rx_bytes_q.push_back(len[8*k +: 8]);
    rx_bytes_q.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < MARK_LEN; k++)
      rx_bytes_q.push_back(SYNC_MARK[8*k +: 8] ^ ((k == bad) ? 8'($urandom_range(1, 255)) : 8'h00));
    if (!broken && len >= MIN_LEN && len <= limit_now)
      repeat (len - MIN_LEN) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queue a frame header and only the first few bytes of its payload
  task automatic push_open_frame(input logic [31:0] len, input int unsigned body);
    for (int k = 0; k < LEN_BYTES; k++) rx_bytes_q.push_back(len[8*k +: 8]);
    rx_bytes_q.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < MARK_LEN; k++) rx_bytes_q.push_back(SYNC_MARK[8*k +: 8]);
    repeat (body) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Mostly lengths the block accepts (kept short), the rest out of range
  function automatic logic [31:0] pick_length();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (r < 75 && limit_now >= MIN_LEN) begin
      if (r < 6 && limit_now <= 300) return limit_now;
      span = (limit_now - MIN_LEN < 24) ? limit_now - MIN_LEN : 24;
      return MIN_LEN + $urandom_range(0, span);
    end
    if (r < 85) return $urandom_range(0, MIN_LEN - 1);
    if (r < 93 && limit_now < LEN_CAP) return limit_now + 1 + $urandom_range(0, 20);
    return $urandom | 32'h0001_0000;
  endfunction

  // Random traffic: mostly frames with random content, some noise and some
  // headers that stop partway through the marker
  task automatic push_random(input int unsigned target);
    int unsigned start;
    int unsigned r;
    int unsigned cut;
    logic [31:0] len;
    start = rx_bytes_q.size();
    while (rx_bytes_q.size() - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_frame(pick_length(), r < 8);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = pick_length();
        cut = $urandom_range(1, MARK_LEN - 1);
        for (int k = 0; k < LEN_BYTES; k++) rx_bytes_q.push_back(len[8*k +: 8]);
        rx_bytes_q.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < cut; k++) rx_bytes_q.push_back(SYNC_MARK[8*k +: 8]);
      end
    end
  endtask

  // Wait until every byte is sent and every due beat has arrived, then let
  // the pipeline settle
  task automatic drain();
    while (rx_bytes_q.size() != 0 || in_tvalid || beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the length limit while the block is idle
  task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = (v > LEN_CAP) ? LEN_CAP : v;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset limit: too-short length, shortest frame, frame with one trailing byte
    push_frame(32'd8, 1'b0);
    push_frame(32'd9, 1'b0);
    push_frame(32'd10, 1'b0);
    push_random(12);
    drain();

    // Register above the buffer cap: the cap rules. One past the cap and an
    // all-ones length word
    write_max_len({MAX_LEN_W{1'b1}});
    push_frame(LEN_CAP + 1, 1'b0);
    push_frame(32'hFFFF_FFFF, 1'b0);
    push_random(12);
    drain();

    // Limit below nine: every marker hit is an error
    write_max_len('0);
    push_frame(32'd9, 1'b0);
    push_random(8);
    drain();

    // Tightest useful limit: only nine-byte frames pass
    write_max_len(MAX_LEN_W'(MIN_LEN));
    push_random(12);
    drain();

    write_max_len(MAX_LEN_W'($urandom_range(10, 40)));
    push_random(16);
    drain();

    // Back to the reset limit; end on a frame right at the buffer cap, of
    // which only the opening beats and a few payload bytes are sent
    write_max_len(MAX_LEN_RST);
    push_random(8);
    push_open_frame(LEN_CAP, 4);
    drain();

    if (mismatches == 0) begin
      $display("PASS length_prefixed_frame_sync");
    end else begin
      $display("FAIL length_prefixed_frame_sync");
    end
    $finish;
  end

endmodule
